// ===== rtl/core/plt_pkg.sv =====
// Shared types and constants for the partition label table.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

  localparam int NUM_ELEMENTS = 1024;
  localparam int ELEM_BITS    = $clog2(NUM_ELEMENTS);
  localparam int LABEL_BITS   = 16;
  localparam int CMD_BITS     = 3;
  localparam int STATUS_BITS  = 3;
  localparam int ROOM_BITS    = ((LABEL_BITS > ELEM_BITS) ? LABEL_BITS : ELEM_BITS) + 1;

  localparam logic [LABEL_BITS-1:0] LABEL_LIMIT = {{(LABEL_BITS-1){1'b1}}, 1'b0};
  localparam logic [ELEM_BITS-1:0]  LAST_ENTRY  = ELEM_BITS'(NUM_ELEMENTS - 1);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD        = 3'd0,
    CMD_MOVE       = 3'd1,
    CMD_SINGLE     = 3'd2,
    CMD_ALL_SINGLE = 3'd3,
    CMD_MERGE      = 3'd4,
    CMD_SAME       = 3'd5,
    CMD_CONTAINS   = 3'd6,
    CMD_ONE_SUBSET = 3'd7
  } plt_cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_ASSIGNED  = 3'd1,
    ST_NO_LABEL  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_RANGE     = 3'd4
  } plt_status_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   command;
    logic [ELEM_BITS-1:0]  element;
    logic [ELEM_BITS-1:0]  other_element;
    logic [LABEL_BITS-1:0] subset;
    logic [LABEL_BITS-1:0] other_subset;
  } plt_in_t;

  typedef struct packed {
    logic                   answer;
    logic [LABEL_BITS-1:0]  new_label;
    logic [LABEL_BITS-1:0]  label_bound;
    logic [STATUS_BITS-1:0] status;
  } plt_out_t;

  typedef struct packed {
    logic                  valid;
    logic [LABEL_BITS-1:0] label;
  } plt_entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic eval;
    logic walk;
    logic xfer;
  } plt_ctl_t;

  typedef struct packed {
    logic clear_last;
    logic walk_last;
    logic need_walk;
  } plt_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/plt_ctrl.sv =====
// Control state machine that sequences clearing, lookup, evaluation and table walks.
`timescale 1ns / 1ps
`default_nettype none

module plt_ctrl
  import plt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire plt_stat_t stat,
  output plt_ctl_t       ctl
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_LOOKUP = 7'b0000100,
    S_EVAL   = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_DRAIN  = 7'b0100000,
    S_FIN    = 7'b1000000
  } plt_state_t;

  plt_state_t st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    st_nxt = st_r;
    ctl    = '0;
    unique case (st_r)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          st_nxt   = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        st_nxt = S_EVAL;
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        st_nxt   = stat.need_walk ? S_WALK : S_FIN;
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (stat.walk_last) begin
          st_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        st_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.xfer = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    if (ctl.xfer) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A new transaction is never taken in the cycle after one was taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("plt_ctrl: input taken twice in a row");

  // A result is moved to the output register only when that register is free.
  a_xfer_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.xfer |-> (!out_valid_r || !out_stall))
    else $error("plt_ctrl: result overwrote a pending transaction");

  // The table clearing pass holds off input right after reset.
  a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !$past(rst_n)) |-> in_stall)
    else $error("plt_ctrl: input accepted during clearing pass");

endmodule

`default_nettype wire

// ===== rtl/core/plt_datapath.sv =====
// Datapath with the label table memory, label counter, checks and result registers.
`timescale 1ns / 1ps
`default_nettype none

module plt_datapath
  import plt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire plt_in_t              in_data,
  input  wire logic                 cfg_we,
  input  wire logic [ELEM_BITS-1:0] cfg_wdata,
  input  wire plt_ctl_t             ctl,
  output plt_stat_t                 stat,
  output plt_out_t                  out_data
);

  plt_entry_t mem [NUM_ELEMENTS];
  plt_entry_t rd_a_r, rd_b_r;

  logic [ELEM_BITS-1:0]  top_r, top_nxt;
  logic [LABEL_BITS-1:0] highest_r, highest_nxt;
  logic [ELEM_BITS-1:0]  idx_r, idx_nxt;
  logic [ELEM_BITS-1:0]  pidx_r, pidx_nxt;
  logic                  pend_r, pend_nxt;
  plt_in_t               op_r, op_nxt;
  plt_out_t              res_r, res_nxt;
  plt_out_t              out_r, out_nxt;

  logic                  wr_en;
  logic [ELEM_BITS-1:0]  wr_addr;
  plt_entry_t            wr_data;
  logic [ELEM_BITS-1:0]  addr_a, addr_b;

  logic                  e1_oor, e2_oor;
  logic [LABEL_BITS-1:0] hl_inc, hl_inc2, fresh_all;
  logic [ROOM_BITS-1:0]  room, need;
  logic                  same_b;
  logic                  walk_last;
  logic                  need_walk;

  assign addr_a = (op_r.command == CMD_ONE_SUBSET) ? '0 : op_r.element;
  assign addr_b = ctl.walk ? idx_r : op_r.other_element;

  assign e1_oor    = op_r.element > top_r;
  assign e2_oor    = op_r.other_element > top_r;
  assign hl_inc    = highest_r + LABEL_BITS'(1);
  assign hl_inc2   = highest_r + LABEL_BITS'(2);
  assign fresh_all = highest_r + LABEL_BITS'(top_r) + LABEL_BITS'(1);
  assign room      = ROOM_BITS'(LABEL_LIMIT - highest_r);
  assign need      = ROOM_BITS'(top_r) + ROOM_BITS'(1);
  assign walk_last = (idx_r == top_r);
  assign same_b    = (rd_a_r.valid == rd_b_r.valid) &&
                     (!rd_a_r.valid || (rd_a_r.label == rd_b_r.label));

  assign stat.clear_last = (idx_r == LAST_ENTRY);
  assign stat.walk_last  = walk_last;
  assign stat.need_walk  = need_walk;
  assign out_data        = out_r;

  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = '0;
    top_nxt        = top_r;
    highest_nxt    = highest_r;
    idx_nxt        = idx_r;
    pidx_nxt       = pidx_r;
    pend_nxt       = 1'b0;
    op_nxt         = op_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    need_walk      = 1'b0;

    if (cfg_we) begin
      top_nxt = cfg_wdata;
    end
    if (ctl.load) begin
      op_nxt = in_data;
    end
    if (ctl.clear) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = '0;
      idx_nxt = idx_r + ELEM_BITS'(1);
    end

    if (ctl.eval) begin
      idx_nxt             = '0;
      res_nxt.answer      = 1'b0;
      res_nxt.new_label   = '0;
      res_nxt.label_bound = hl_inc;
      res_nxt.status      = ST_OK;
      unique case (op_r.command)
        CMD_ADD, CMD_MOVE: begin
          if (e1_oor) begin
            res_nxt.status = ST_RANGE;
          end else if ((op_r.command == CMD_ADD) && rd_a_r.valid) begin
            res_nxt.status = ST_ASSIGNED;
          end else if (op_r.subset > highest_r) begin
            res_nxt.status = ST_NO_LABEL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = op_r.element;
            wr_data.valid = 1'b1;
            wr_data.label = op_r.subset;
          end
        end
        CMD_SINGLE: begin
          if (e1_oor) begin
            res_nxt.status = ST_RANGE;
          end else if (highest_r >= LABEL_LIMIT) begin
            res_nxt.status = ST_EXHAUSTED;
          end else begin
            highest_nxt         = hl_inc;
            wr_en               = 1'b1;
            wr_addr             = op_r.element;
            wr_data.valid       = 1'b1;
            wr_data.label       = hl_inc;
            res_nxt.new_label   = hl_inc;
            res_nxt.label_bound = hl_inc2;
          end
        end
        CMD_ALL_SINGLE: begin
          if (room < need) begin
            res_nxt.status = ST_EXHAUSTED;
          end else begin
            need_walk           = 1'b1;
            res_nxt.new_label   = fresh_all;
            res_nxt.label_bound = fresh_all + LABEL_BITS'(1);
          end
        end
        CMD_MERGE: begin
          if ((op_r.subset > highest_r) || (op_r.other_subset > highest_r)) begin
            res_nxt.status = ST_NO_LABEL;
          end else if (highest_r >= LABEL_LIMIT) begin
            res_nxt.status = ST_EXHAUSTED;
          end else begin
            need_walk           = 1'b1;
            highest_nxt         = hl_inc;
            res_nxt.new_label   = hl_inc;
            res_nxt.label_bound = hl_inc2;
          end
        end
        CMD_SAME: begin
          if (e1_oor || e2_oor) begin
            res_nxt.status = ST_RANGE;
          end else begin
            res_nxt.answer = rd_a_r.valid && rd_b_r.valid &&
                             (rd_a_r.label == rd_b_r.label);
          end
        end
        CMD_CONTAINS: begin
          res_nxt.answer = !e1_oor && rd_a_r.valid;
        end
        CMD_ONE_SUBSET: begin
          res_nxt.answer = 1'b1;
          need_walk      = 1'b1;
        end
      endcase
    end

    if (ctl.walk) begin
      pend_nxt = 1'b1;
      pidx_nxt = idx_r;
      if (!walk_last) begin
        idx_nxt = idx_r + ELEM_BITS'(1);
      end
      if (op_r.command == CMD_ALL_SINGLE) begin
        wr_en         = 1'b1;
        wr_addr       = idx_r;
        wr_data.valid = 1'b1;
        wr_data.label = hl_inc;
        highest_nxt   = hl_inc;
      end
    end

    if (pend_r) begin
      if ((op_r.command == CMD_MERGE) && rd_b_r.valid &&
          ((rd_b_r.label == op_r.subset) || (rd_b_r.label == op_r.other_subset))) begin
        wr_en         = 1'b1;
        wr_addr       = pidx_r;
        wr_data.valid = 1'b1;
        wr_data.label = highest_r;
      end
      if ((op_r.command == CMD_ONE_SUBSET) && !same_b) begin
        res_nxt.answer = 1'b0;
      end
    end

    if (ctl.xfer) begin
      out_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r     <= {ELEM_BITS{1'b1}};
      highest_r <= '0;
      idx_r     <= '0;
      pend_r    <= 1'b0;
    end else begin
      top_r     <= top_nxt;
      highest_r <= highest_nxt;
      idx_r     <= idx_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    op_r   <= op_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // The label counter stops at the limit and never wraps.
  a_label_limit: assert property (@(posedge clk) disable iff (!rst_n)
    highest_r <= LABEL_LIMIT)
    else $error("plt_datapath: label counter beyond limit");

  // Outside reset the label counter only grows.
  a_label_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (highest_r >= $past(highest_r)))
    else $error("plt_datapath: label counter went down");

endmodule

`default_nettype wire

// ===== rtl/core/partition_label_table_core.sv =====
// Top level of the partition label table: controller, datapath and ports.
// Flow: a transaction passes through the lookup and evaluation states, and its result is
// registered when the output register is free; all singletons, merge and the one subset
// test also walk the table from entry 0 to top, the element bound set through cfg_wdata,
// one entry a cycle. A new transaction is taken only after the last result is transferred.
// Reset: a clearing pass writes all 1024 entries, one per cycle, with in_stall high.
`timescale 1ns / 1ps
`default_nettype none

module partition_label_table_core
  import plt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire plt_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output plt_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [ELEM_BITS-1:0] cfg_wdata
);

  plt_ctl_t  ctl;
  plt_stat_t stat;

  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  plt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
